// File: hw/rtl/kbct_pkg.sv
// kbct_pkg: shared types, constants and the keypad decode function for the
// keypad bcd countdown timer. No dependencies; imported by every rtl module.
package kbct_pkg;

    localparam int DIGIT_W     = 4;
    localparam int DIGIT_COUNT = 6;
    localparam int POS_W       = 3;   // entry position 0..6
    localparam int CODE_W      = 5;
    localparam int TICK_W      = 8;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 32;

    localparam logic [DIGIT_W-1:0] BLANK_DIGIT        = 4'd10;
    localparam logic [TICK_W-1:0]  TICK_COMPARE_RESET = 8'd29;
    localparam logic [POS_W-1:0]   POS_FULL           = 3'd6;

    // event kinds on s_tuser
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // decoded key kinds
    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_DIGIT = 2'd1;
    localparam logic [1:0] KEY_STAR  = 2'd2;
    localparam logic [1:0] KEY_HASH  = 2'd3;

    typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits_t;  // index 0 is hours tens

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] key_code;
    } item_t;

    typedef struct packed {
        logic               display_updated;
        logic               counting;
        digits_t            digits;
    } result_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [DIGIT_W-1:0] value;
    } key_t;

    function automatic key_t key_decode(input logic [CODE_W-1:0] code);
        key_t k;
        k.kind  = KEY_DIGIT;
        k.value = '0;
        case (code)
            5'd1:    k.value = 4'd1;
            5'd2:    k.value = 4'd2;
            5'd3:    k.value = 4'd3;
            5'd5:    k.value = 4'd4;
            5'd6:    k.value = 4'd5;
            5'd7:    k.value = 4'd6;
            5'd9:    k.value = 4'd7;
            5'd10:   k.value = 4'd8;
            5'd11:   k.value = 4'd9;
            5'd14:   k.value = 4'd0;
            5'd13:   k.kind  = KEY_STAR;
            5'd15:   k.kind  = KEY_HASH;
            default: k.kind  = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/kbct_in_stage.sv
// kbct_in_stage: input register for the event stream.
// Depends on kbct_pkg for item_t.
module kbct_in_stage import kbct_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t s_item,
    input  logic  advance,    // downstream takes the held word this cycle
    output logic  held_valid,
    output item_t held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// File: hw/rtl/kbct_core.sv
// kbct_core: timer state (digits, entry position, running flag, prescaler,
// tick_compare) and the single-pass next-state logic. Depends on kbct_pkg.
module kbct_core import kbct_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [TICK_W-1:0] cfg_wdata,
    input  logic              go,
    input  item_t             item,
    output result_t           result
);

    localparam digits_t TOPS = {4'd9, 4'd5, 4'd9, 4'd5, 4'd9, 4'd9};

    digits_t           digit_reg, digit_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              running_reg, running_next;
    logic [TICK_W-1:0] tick_cnt_reg, tick_cnt_next;
    logic [TICK_W-1:0] tick_cmp_reg;

    key_t              key;
    digits_t           dec_digits;
    logic              all_zero;
    logic              borrow;
    logic              updated;
    logic [POS_W-1:0]  wr_idx;

    assign key    = key_decode(item.key_code);
    assign wr_idx = POS_W'(DIGIT_COUNT - 1) - pos_reg;

    // cascaded bcd decrement, seconds units first, holding at all zeros
    always_comb begin
        all_zero   = (digit_reg == '0);
        dec_digits = digit_reg;
        borrow     = !all_zero;
        for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
            if (borrow) begin
                if (digit_reg[i] == '0) begin
                    dec_digits[i] = TOPS[i];
                end else begin
                    dec_digits[i] = digit_reg[i] - 4'd1;
                    borrow        = 1'b0;
                end
            end
        end
    end

    always_comb begin
        digit_next    = digit_reg;
        pos_next      = pos_reg;
        running_next  = running_reg;
        tick_cnt_next = tick_cnt_reg;
        updated       = 1'b0;
        if (go) begin
            if (item.mode == MODE_TICK) begin
                if (running_reg) begin
                    if (tick_cnt_reg == tick_cmp_reg) begin
                        digit_next    = dec_digits;
                        updated       = 1'b1;
                        tick_cnt_next = TICK_W'(1);
                    end else begin
                        tick_cnt_next = tick_cnt_reg + TICK_W'(1);
                    end
                end
            end else begin
                case (key.kind)
                    KEY_STAR: begin
                        digit_next    = {DIGIT_COUNT{BLANK_DIGIT}};
                        pos_next      = '0;
                        running_next  = 1'b0;
                        tick_cnt_next = '0;
                        updated       = 1'b1;
                    end
                    KEY_HASH: begin
                        if (!running_reg) begin
                            for (int i = 0; i < DIGIT_COUNT; i++) begin
                                if (digit_reg[i] == BLANK_DIGIT) begin
                                    digit_next[i] = '0;
                                end
                            end
                            running_next  = 1'b1;
                            tick_cnt_next = '0;
                        end
                    end
                    KEY_DIGIT: begin
                        if (!running_reg && pos_reg < POS_FULL) begin
                            digit_next[wr_idx] = key.value;
                            pos_next           = pos_reg + POS_W'(1);
                            updated            = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg    <= {DIGIT_COUNT{BLANK_DIGIT}};
            pos_reg      <= '0;
            running_reg  <= 1'b0;
            tick_cnt_reg <= '0;
            tick_cmp_reg <= TICK_COMPARE_RESET;
        end else begin
            digit_reg    <= digit_next;
            pos_reg      <= pos_next;
            running_reg  <= running_next;
            tick_cnt_reg <= tick_cnt_next;
            if (cfg_we) begin
                tick_cmp_reg <= cfg_wdata;
            end
        end
    end

    assign result.digits          = digit_next;
    assign result.counting        = running_next;
    assign result.display_updated = updated;

endmodule

// File: hw/rtl/kbct_out_stage.sv
// kbct_out_stage: result register driving the master stream.
// Depends on kbct_pkg for result_t.
module kbct_out_stage import kbct_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  result_t             result,
    output logic                advance,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign advance    = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_DATA_W'(data_reg);

endmodule

// File: hw/rtl/keypad_bcd_countdown_timer.sv
// keypad_bcd_countdown_timer: top level, input register, state core and result register.
// Depends on kbct_pkg, kbct_in_stage, kbct_core and kbct_out_stage.
//
// Takes one event word per clock (s_tuser 0: keypad code in s_tdata, 1: prescaler tick)
// and returns one result word per event: each accepted event is held in the input
// register, then the whole digit entry / start / bcd decrement step runs in one
// pass into the result register. Back pressure on m_tready stalls both registers in
// step; with m_tready held high the block sustains one event every cycle. tick_compare
// is written through cfg_we/cfg_wdata and should change only while no event is in flight.
module keypad_bcd_countdown_timer import kbct_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [TICK_W-1:0]   cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [4:0] key_code, [7:5] zero
    input  logic                s_tuser,   // [0] mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [3:0] hour_tens, [7:4] hour_units,
                                           // [11:8] minute_tens, [15:12] minute_units,
                                           // [19:16] second_tens, [23:20] second_units,
                                           // [24] counting, [25] display_updated, [31:26] 0
);

    item_t   s_item;
    item_t   held_item;
    logic    held_valid;
    logic    advance;
    logic    go;
    result_t result;

    assign s_item.mode     = s_tuser;
    assign s_item.key_code = s_tdata[CODE_W-1:0];
    assign go              = held_valid && advance;

    kbct_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    kbct_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .go        (go),
        .item      (held_item),
        .result    (result)
    );

    kbct_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (go),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
